/* design/rbs_pkg.sv */
package rbs_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int NUM_AXES  = 3;
   localparam int NUM_LANES = 2 * NUM_AXES;
   localparam int NUM_REGS  = NUM_LANES;
   localparam int IDX_WIDTH = 3;

   // Per-ray flags carried beside the divider lanes: lane signs, zero axes, inside axes.
   localparam int SIDE_FLAGS = NUM_LANES + 2 * NUM_AXES;

   typedef enum logic [IDX_WIDTH-1:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } reg_index_type;

endpackage

/* design/rbs_front.sv */
module rbs_front
   import rbs_pkg::*;
#(
   parameter int W  = COORD_WIDTH_DEF,
   parameter int F  = FRAC_BITS_DEF,
   parameter int NB = W + 1 + F,
   parameter int SW = W + SIDE_FLAGS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [NUM_AXES-1:0][W-1:0] org,
   input  logic signed [NUM_AXES-1:0][W-1:0] dir,
   input  logic signed [W-1:0]             nearest,
   input  logic        [NUM_LANES-1:0][W-1:0] box,
   output logic                            valid_o,
   output logic [NUM_LANES-1:0][NB-1:0]    nq_o,
   output logic [NUM_LANES-1:0][W-1:0]     dmag_o,
   output logic [SW-1:0]                   side_o
);

   logic                          valid_ff;
   logic [NUM_LANES-1:0][NB-1:0]  nq_ff, nq_in;
   logic [NUM_LANES-1:0][W-1:0]   dmag_ff, dmag_in;
   logic [SW-1:0]                 side_ff, side_in;

   always_comb begin
      logic signed [W:0] num;
      logic [W:0]        mag;
      logic [NUM_LANES-1:0] neg;
      logic [NUM_AXES-1:0]  zero, in_slab;
      int                   a;
      for (int l = 0; l < NUM_LANES; l++) begin
         a = l % NUM_AXES;
         num = {box[l][W-1], box[l]} - {org[a][W-1], org[a]};
         mag = num[W] ? (W+1)'(-num) : num;
         nq_in[l] = {mag, {F{1'b0}}};
         dmag_in[l] = dir[a][W-1] ? W'(-dir[a]) : dir[a];
         neg[l] = num[W] ^ dir[a][W-1];
      end
      for (int k = 0; k < NUM_AXES; k++) begin
         zero[k] = (dir[k] == '0);
         in_slab[k] = ($signed(box[k]) <= $signed(org[k])) &&
                      ($signed(org[k]) <= $signed(box[k + NUM_AXES]));
      end
      side_in = {nearest, neg, zero, in_slab};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         nq_ff   <= nq_in;
         dmag_ff <= dmag_in;
         side_ff <= side_in;
      end
   end

   assign valid_o = valid_ff;
   assign nq_o    = nq_ff;
   assign dmag_o  = dmag_ff;
   assign side_o  = side_ff;

endmodule

/* design/rbs_div_cell.sv */
module rbs_div_cell
   import rbs_pkg::*;
#(
   parameter int W  = COORD_WIDTH_DEF,
   parameter int NB = W + 1 + FRAC_BITS_DEF,
   parameter int SW = W + SIDE_FLAGS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          valid_i,
   input  logic [NUM_LANES-1:0][NB-1:0]  nq_i,
   input  logic [NUM_LANES-1:0][W-1:0]   rem_i,
   input  logic [NUM_LANES-1:0][W-1:0]   dmag_i,
   input  logic [SW-1:0]                 side_i,
   output logic                          valid_o,
   output logic [NUM_LANES-1:0][NB-1:0]  nq_o,
   output logic [NUM_LANES-1:0][W-1:0]   rem_o,
   output logic [NUM_LANES-1:0][W-1:0]   dmag_o,
   output logic [SW-1:0]                 side_o
);

   logic                          valid_ff;
   logic [NUM_LANES-1:0][NB-1:0]  nq_ff, nq_in;
   logic [NUM_LANES-1:0][W-1:0]   rem_ff, rem_in;
   logic [NUM_LANES-1:0][W-1:0]   dmag_ff;
   logic [SW-1:0]                 side_ff;

   // One restoring step: the numerator shifts out at the top while
   // quotient bits shift in at the bottom of the same register.
   always_comb begin
      logic [W-1:0] cur;
      logic         take;
      for (int l = 0; l < NUM_LANES; l++) begin
         cur  = {rem_i[l][W-2:0], nq_i[l][NB-1]};
         take = (cur >= dmag_i[l]);
         rem_in[l] = take ? (cur - dmag_i[l]) : cur;
         nq_in[l]  = {nq_i[l][NB-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
      if (adv) begin
         nq_ff   <= nq_in;
         rem_ff  <= rem_in;
         dmag_ff <= dmag_i;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign nq_o    = nq_ff;
   assign rem_o   = rem_ff;
   assign dmag_o  = dmag_ff;
   assign side_o  = side_ff;

endmodule

/* design/rbs_back.sv */
module rbs_back
   import rbs_pkg::*;
#(
   parameter int W  = COORD_WIDTH_DEF,
   parameter int NB = W + 1 + FRAC_BITS_DEF,
   parameter int SW = W + SIDE_FLAGS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          valid_i,
   input  logic [NUM_LANES-1:0][NB-1:0]  q_i,
   input  logic [SW-1:0]                 side_i,
   output logic                          valid_o,
   output logic                          hit_o,
   output logic signed [W-1:0]           nearest_o
);

   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [NB-1:0]       HALF = {{(NB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   logic                                 sl_valid_ff;
   logic signed [NUM_AXES-1:0][W-1:0]    near_ff, near_in, far_ff, far_in;
   logic signed [W-1:0]                  sl_nearest_ff;
   logic                                 valid_ff;
   logic                                 hit_ff, hit_in;
   logic signed [W-1:0]                  nearest_ff, nearest_in;

   // Saturate the quotients, then order each axis' crossings.
   always_comb begin
      logic signed [NUM_LANES-1:0][W-1:0] t;
      logic [NUM_LANES-1:0] neg;
      logic [NUM_AXES-1:0]  zero, in_slab;
      neg     = side_i[2*NUM_AXES +: NUM_LANES];
      zero    = side_i[NUM_AXES +: NUM_AXES];
      in_slab = side_i[0 +: NUM_AXES];
      for (int l = 0; l < NUM_LANES; l++) begin
         if (neg[l]) begin
            t[l] = (q_i[l] > HALF) ? MINV : W'(-q_i[l]);
         end else begin
            t[l] = (q_i[l] >= HALF) ? MAXV : q_i[l][W-1:0];
         end
      end
      for (int k = 0; k < NUM_AXES; k++) begin
         if (zero[k]) begin
            near_in[k] = in_slab[k] ? MINV : MAXV;
            far_in[k]  = in_slab[k] ? MAXV : MINV;
         end else if ($signed(t[k]) < $signed(t[k + NUM_AXES])) begin
            near_in[k] = t[k];
            far_in[k]  = t[k + NUM_AXES];
         end else begin
            near_in[k] = t[k + NUM_AXES];
            far_in[k]  = t[k];
         end
      end
   end

   always_comb begin
      logic signed [W-1:0] entry, exitd, hitd;
      entry = near_ff[0];
      exitd = far_ff[0];
      for (int k = 1; k < NUM_AXES; k++) begin
         if ($signed(near_ff[k]) > entry) entry = near_ff[k];
         if ($signed(far_ff[k]) < exitd) exitd = far_ff[k];
      end
      hitd = (entry > 0) ? entry : exitd;
      hit_in = !((exitd < 0) || (exitd < hitd) || (hitd > sl_nearest_ff));
      nearest_in = hit_in ? hitd : sl_nearest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (adv) begin
         sl_valid_ff <= valid_i;
         valid_ff    <= sl_valid_ff;
      end
      if (adv) begin
         near_ff       <= near_in;
         far_ff        <= far_in;
         sl_nearest_ff <= side_i[SW-1 -: W];
         hit_ff        <= hit_in;
         nearest_ff    <= nearest_in;
      end
   end

   assign valid_o   = valid_ff;
   assign hit_o     = hit_ff;
   assign nearest_o = nearest_ff;

endmodule

/* design/ray_box_slab_intersect.sv */
// Ray against axis-aligned box, slab method, signed fixed point.
//
// The box corners live in six registers written through the csr_ port
// (index 0..2 lower corner x,y,z, 3..5 upper corner); writes take effect
// at once and should only happen while no request is in flight.
// Each request on the req_ channel carries one ray and the nearest hit
// distance so far; exactly one response follows on the rsp_ channel with
// the hit flag and the updated nearest distance.
//
// A request passes one front stage, one divider cell per quotient bit and
// two result stages. Throughput is one request per cycle while the
// receiver does not stall; the six divisions of a ray run side by side in
// every cell of the chain.
// When the receiver stalls, the whole chain holds and req_ready drops in
// the same cycle, so nothing is lost. Synchronous reset empties the chain
// and clears the box registers to zero.
module ray_box_slab_intersect
   import rbs_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_nearest_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_nearest_out,
   input  logic                          csr_we,
   input  logic [IDX_WIDTH-1:0]          csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);

   localparam int W  = COORD_WIDTH;
   localparam int NB = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int SW = COORD_WIDTH + SIDE_FLAGS;

   logic [NUM_LANES-1:0][W-1:0] box_ff;
   logic                        adv;

   // All stages move together; a stage is free to move whenever the
   // response register is empty or being taken.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_X: box_ff[REG_MIN_X] <= csr_wdata;
            REG_MIN_Y: box_ff[REG_MIN_Y] <= csr_wdata;
            REG_MIN_Z: box_ff[REG_MIN_Z] <= csr_wdata;
            REG_MAX_X: box_ff[REG_MAX_X] <= csr_wdata;
            REG_MAX_Y: box_ff[REG_MAX_Y] <= csr_wdata;
            REG_MAX_Z: box_ff[REG_MAX_Z] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Chain links: index 0 is the front stage output, index NB the last cell.
   logic                         c_valid [NB+1];
   logic [NUM_LANES-1:0][NB-1:0] c_nq    [NB+1];
   logic [NUM_LANES-1:0][W-1:0]  c_rem   [NB+1];
   logic [NUM_LANES-1:0][W-1:0]  c_dmag  [NB+1];
   logic [SW-1:0]                c_side  [NB+1];

   rbs_front #(.W(W), .F(FRAC_BITS), .NB(NB), .SW(SW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .org      ({req_origin_z, req_origin_y, req_origin_x}),
      .dir      ({req_dir_z, req_dir_y, req_dir_x}),
      .nearest  (req_nearest_in),
      .box      (box_ff),
      .valid_o  (c_valid[0]),
      .nq_o     (c_nq[0]),
      .dmag_o   (c_dmag[0]),
      .side_o   (c_side[0])
   );

   // The partial remainder starts at zero for every division.
   assign c_rem[0] = '0;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      rbs_div_cell #(.W(W), .NB(NB), .SW(SW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .valid_i (c_valid[i]),
         .nq_i    (c_nq[i]),
         .rem_i   (c_rem[i]),
         .dmag_i  (c_dmag[i]),
         .side_i  (c_side[i]),
         .valid_o (c_valid[i+1]),
         .nq_o    (c_nq[i+1]),
         .rem_o   (c_rem[i+1]),
         .dmag_o  (c_dmag[i+1]),
         .side_o  (c_side[i+1])
      );
   end

   // The final remainder and divisor are not needed by the result stages.
   rbs_back #(.W(W), .NB(NB), .SW(SW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_i   (c_valid[NB]),
      .q_i       (c_nq[NB]),
      .side_i    (c_side[NB]),
      .valid_o   (rsp_valid),
      .hit_o     (rsp_hit),
      .nearest_o (rsp_nearest_out)
   );

endmodule
